/* rtl/pts_pkg.sv */
`timescale 1ns / 1ps

package pts_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned CPUS   = 4;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned ID_W   = 32;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_SCHED  = 2'd1,
    ACT_YIELD  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_NO_SLOT       = 2'd1,
    STAT_NONE_RUNNABLE = 2'd2,
    STAT_NO_CURRENT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2
  } slot_st_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LAST,
    FSM_COMMIT
  } fsm_e;

  typedef struct packed {
    logic [1:0]        st;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } slot_entry_t;

  // Fold the 2-bit processor number onto the CPUS records.
  function automatic logic [CPU_W-1:0] cpu_index(input logic [1:0] c);
    logic [CPU_W-1:0] r;
    case (c)
      2'd0:    r = CPU_W'(0 % CPUS);
      2'd1:    r = CPU_W'(1 % CPUS);
      2'd2:    r = CPU_W'(2 % CPUS);
      2'd3:    r = CPU_W'(3 % CPUS);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/priority_task_scheduler.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                                   Transfer
// command   in         start_i, action_i, cpu_i, priority_req_i  start_i && !busy_o
// result    out        done_o, status_o, slot_o, task_id_o       done_o (one cycle)
//
// Create and schedule walk the table one entry per cycle on the single read
// port, then commit; busy_o stays high while the result is shown (create
// stops at the first free slot). Yield commits after one read of its slot, or
// at once with no current task. An unknown action is dropped with no result.
// Reset clears the slot valid bits, the processor records and the id counter;
// no clearing pass. The result is shown for one cycle and cannot be stalled.

module priority_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  cpu_i,
  input  logic [7:0]  priority_req_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [31:0] task_id_o
);

  pts_pkg::fsm_e state_q, state_d;

  // Table memory
  pts_pkg::slot_entry_t mem [pts_pkg::SLOTS];
  pts_pkg::slot_entry_t rd_data_q;
  pts_pkg::slot_entry_t wr_data;
  logic                 wr_en;
  logic [pts_pkg::SLOT_W-1:0] rd_addr;
  logic [pts_pkg::SLOTS-1:0]  vld_q, vld_d;

  // Operation registers
  pts_pkg::action_e             act_q, act_d;
  logic [pts_pkg::CPU_W-1:0]    cpu_q, cpu_d;
  logic [pts_pkg::PRIO_W-1:0]   prio_q, prio_d;
  logic [pts_pkg::SLOT_W-1:0]   addr_q, addr_d;
  logic [pts_pkg::SLOT_W-1:0]   chk_q, chk_d;
  logic                         pend_q, pend_d;
  logic                         found_q, found_d;
  logic [pts_pkg::SLOT_W-1:0]   best_q, best_d;
  logic [pts_pkg::PRIO_W-1:0]   best_prio_q, best_prio_d;
  logic [pts_pkg::ID_W-1:0]     best_id_q, best_id_d;
  logic [pts_pkg::ID_W-1:0]     id_q, id_d;

  logic [pts_pkg::SLOT_W-1:0] cur_slot_q [pts_pkg::CPUS];
  logic [pts_pkg::SLOT_W-1:0] cur_slot_d [pts_pkg::CPUS];
  logic [pts_pkg::CPUS-1:0]   cur_vld_q, cur_vld_d;

  logic                      accept;
  logic [pts_pkg::CPU_W-1:0] cpu_in;
  logic [1:0]                chk_st;
  logic                      create_hit;
  logic [pts_pkg::ID_W-1:0]  id_next;
  logic [pts_pkg::SLOT_W+5:0] slot_ext;

  assign accept  = start_i && (state_q == pts_pkg::FSM_IDLE);
  assign cpu_in  = pts_pkg::cpu_index(cpu_i);
  assign id_next = id_q + pts_pkg::ID_W'(1);
  // Entries never written read as unused.
  assign chk_st  = vld_q[chk_q] ? rd_data_q.st : pts_pkg::ST_UNUSED;
  assign create_hit = pend_q && (act_q == pts_pkg::ACT_CREATE) &&
                      (chk_st == pts_pkg::ST_UNUSED) &&
                      ((state_q == pts_pkg::FSM_SCAN) || (state_q == pts_pkg::FSM_LAST));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::FSM_IDLE: begin
        if (accept) begin
          case (pts_pkg::action_e'(action_i))
            pts_pkg::ACT_CREATE: state_d = pts_pkg::FSM_SCAN;
            pts_pkg::ACT_SCHED:  state_d = pts_pkg::FSM_SCAN;
            pts_pkg::ACT_YIELD: begin
              state_d = cur_vld_q[cpu_in] ? pts_pkg::FSM_LAST : pts_pkg::FSM_COMMIT;
            end
            default: state_d = pts_pkg::FSM_IDLE;
          endcase
        end
      end
      pts_pkg::FSM_SCAN: begin
        if (create_hit) begin
          state_d = pts_pkg::FSM_COMMIT;
        end else if (addr_q == pts_pkg::SLOT_W'(pts_pkg::SLOTS - 1)) begin
          state_d = pts_pkg::FSM_LAST;
        end
      end
      pts_pkg::FSM_LAST:   state_d = pts_pkg::FSM_COMMIT;
      pts_pkg::FSM_COMMIT: state_d = pts_pkg::FSM_IDLE;
      default:             state_d = pts_pkg::FSM_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    act_d       = act_q;
    cpu_d       = cpu_q;
    prio_d      = prio_q;
    addr_d      = addr_q;
    chk_d       = chk_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    best_id_d   = best_id_q;
    id_d        = id_q;
    vld_d       = vld_q;
    cur_vld_d   = cur_vld_q;
    for (int k = 0; k < int'(pts_pkg::CPUS); k++) begin
      cur_slot_d[k] = cur_slot_q[k];
    end
    rd_addr   = addr_q;
    wr_en     = 1'b0;
    wr_data   = '0;
    done_o    = 1'b0;
    status_o  = pts_pkg::STAT_OK;
    slot_ext  = '0;
    task_id_o = '0;

    // Check the entry read in the previous cycle
    if (pend_q && ((state_q == pts_pkg::FSM_SCAN) || (state_q == pts_pkg::FSM_LAST))) begin
      case (act_q)
        pts_pkg::ACT_CREATE: begin
          if (create_hit && !found_q) begin
            found_d = 1'b1;
            best_d  = chk_q;
          end
        end
        pts_pkg::ACT_SCHED: begin
          if ((chk_st == pts_pkg::ST_RUNNABLE) &&
              (!found_q || (rd_data_q.prio < best_prio_q))) begin
            found_d     = 1'b1;
            best_d      = chk_q;
            best_prio_d = rd_data_q.prio;
            best_id_d   = rd_data_q.id;
          end
        end
        pts_pkg::ACT_YIELD: begin
          found_d     = 1'b1;
          best_d      = chk_q;
          best_prio_d = rd_data_q.prio;
          best_id_d   = rd_data_q.id;
        end
        default: ;
      endcase
    end

    case (state_q)
      pts_pkg::FSM_IDLE: begin
        if (accept) begin
          act_d   = pts_pkg::action_e'(action_i);
          cpu_d   = cpu_in;
          prio_d  = priority_req_i;
          addr_d  = '0;
          found_d = 1'b0;
          if ((pts_pkg::action_e'(action_i) == pts_pkg::ACT_YIELD) && cur_vld_q[cpu_in]) begin
            rd_addr = cur_slot_q[cpu_in];
            chk_d   = cur_slot_q[cpu_in];
            pend_d  = 1'b1;
          end
        end
      end
      pts_pkg::FSM_SCAN: begin
        rd_addr = addr_q;
        chk_d   = addr_q;
        pend_d  = 1'b1;
        addr_d  = addr_q + pts_pkg::SLOT_W'(1);
      end
      pts_pkg::FSM_COMMIT: begin
        done_o = 1'b1;
        case (act_q)
          pts_pkg::ACT_CREATE: begin
            if (found_q) begin
              wr_en          = 1'b1;
              wr_data.st     = pts_pkg::ST_RUNNABLE;
              wr_data.prio   = prio_q;
              wr_data.id     = id_next;
              vld_d[best_q]  = 1'b1;
              id_d           = id_next;
              slot_ext       = {6'd0, best_q};
              task_id_o      = id_next;
            end else begin
              status_o = pts_pkg::STAT_NO_SLOT;
            end
          end
          pts_pkg::ACT_SCHED: begin
            if (found_q) begin
              wr_en             = 1'b1;
              wr_data.st        = pts_pkg::ST_RUNNING;
              wr_data.prio      = best_prio_q;
              wr_data.id        = best_id_q;
              cur_slot_d[cpu_q] = best_q;
              cur_vld_d[cpu_q]  = 1'b1;
              slot_ext          = {6'd0, best_q};
              task_id_o         = best_id_q;
            end else begin
              status_o = pts_pkg::STAT_NONE_RUNNABLE;
            end
          end
          pts_pkg::ACT_YIELD: begin
            if (found_q) begin
              wr_en        = 1'b1;
              wr_data.st   = pts_pkg::ST_RUNNABLE;
              wr_data.prio = best_prio_q;
              wr_data.id   = best_id_q;
              slot_ext     = {6'd0, best_q};
              task_id_o    = best_id_q;
            end else begin
              status_o = pts_pkg::STAT_NO_CURRENT;
            end
          end
          default: done_o = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  assign slot_o = slot_ext[5:0];
  assign busy_o = (state_q != pts_pkg::FSM_IDLE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[best_q] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pts_pkg::FSM_IDLE;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      vld_q     <= '0;
      id_q      <= '0;
      cur_vld_q <= '0;
      for (int k = 0; k < int'(pts_pkg::CPUS); k++) begin
        cur_slot_q[k] <= '0;
      end
      act_q     <= pts_pkg::ACT_NONE;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      vld_q     <= vld_d;
      id_q      <= id_d;
      cur_vld_q <= cur_vld_d;
      for (int k = 0; k < int'(pts_pkg::CPUS); k++) begin
        cur_slot_q[k] <= cur_slot_d[k];
      end
      act_q     <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_q       <= cpu_d;
    prio_q      <= prio_d;
    addr_q      <= addr_d;
    chk_q       <= chk_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    best_id_q   <= best_id_d;
  end

  // A known action must make the block busy on the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (action_i != pts_pkg::ACT_NONE)) |=> busy_o)
    else $error("busy not raised after command transfer");

  // Error results carry no slot and no id.
  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != pts_pkg::STAT_OK)) |-> ((slot_o == '0) && (task_id_o == '0)))
    else $error("error result with nonzero slot or id");

  // A successful dispatch leaves a current task on that processor.
  a_sched_sets_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (act_q == pts_pkg::ACT_SCHED) && (status_o == pts_pkg::STAT_OK))
    |=> cur_vld_q[$past(cpu_q)])
    else $error("dispatch did not record current task");

  // The id counter moves only on a successful create.
  a_id_only_on_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(id_q) |-> $past(done_o && (act_q == pts_pkg::ACT_CREATE) &&
                             (status_o == pts_pkg::STAT_OK)))
    else $error("id counter changed outside create");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = pts_pkg::SLOTS + 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    pts_pkg::action_e           act;
    logic [1:0]                 cpu;
    logic [pts_pkg::PRIO_W-1:0] prio;
  } command_t;

  typedef struct packed {
    pts_pkg::status_e         status;
    logic [5:0]               slot;
    logic [pts_pkg::ID_W-1:0] id;
  } outcome_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [1:0]  action_i       = pts_pkg::ACT_CREATE;
  logic [1:0]  cpu_i          = 2'd0;
  logic [7:0]  priority_req_i = 8'd0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [5:0]  slot_o;
  logic [31:0] task_id_o;

  command_t    cmd_q[$];
  outcome_t    outcome_q[$];
  outcome_t    want;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned stall_cycles = 0;

  // Mirror of the task table and the per-processor records.
  pts_pkg::slot_st_e          tbl_state [pts_pkg::SLOTS];
  logic [pts_pkg::PRIO_W-1:0] tbl_prio  [pts_pkg::SLOTS];
  logic [pts_pkg::ID_W-1:0]   tbl_id    [pts_pkg::SLOTS];
  logic [pts_pkg::SLOT_W-1:0] cur_slot  [pts_pkg::CPUS];
  logic                       cur_valid [pts_pkg::CPUS];
  logic [pts_pkg::ID_W-1:0]   last_id;

  priority_task_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .cpu_i          (cpu_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .task_id_o      (task_id_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic run_table_op(input command_t c);
    outcome_t    o;
    int unsigned k;
    int unsigned best;
    int unsigned p;
    bit          found;
    o.status = pts_pkg::STAT_OK;
    o.slot   = '0;
    o.id     = '0;
    p        = c.cpu % pts_pkg::CPUS;
    found    = 1'b0;
    best     = 0;
    case (c.act)
      pts_pkg::ACT_CREATE: begin
        for (k = 0; k < pts_pkg::SLOTS && !found; k++) begin
          if (tbl_state[k] == pts_pkg::ST_UNUSED) begin
            found        = 1'b1;
            last_id      = last_id + 1;
            tbl_id[k]    = last_id;
            tbl_state[k] = pts_pkg::ST_RUNNABLE;
            tbl_prio[k]  = c.prio;
            o.slot       = 6'(k);
            o.id         = last_id;
          end
        end
        if (!found) o.status = pts_pkg::STAT_NO_SLOT;
      end
      pts_pkg::ACT_SCHED: begin
        for (k = 0; k < pts_pkg::SLOTS; k++) begin
          if (tbl_state[k] == pts_pkg::ST_RUNNABLE &&
              (!found || tbl_prio[k] < tbl_prio[best])) begin
            found = 1'b1;
            best  = k;
          end
        end
        if (found) begin
          tbl_state[best] = pts_pkg::ST_RUNNING;
          cur_slot[p]     = pts_pkg::SLOT_W'(best);
          cur_valid[p]    = 1'b1;
          o.slot          = 6'(best);
          o.id            = tbl_id[best];
        end else begin
          o.status = pts_pkg::STAT_NONE_RUNNABLE;
        end
      end
      pts_pkg::ACT_YIELD: begin
        if (cur_valid[p]) begin
          // The record stays; the slot goes runnable whatever its state.
          best            = cur_slot[p] % pts_pkg::SLOTS;
          tbl_state[best] = pts_pkg::ST_RUNNABLE;
          o.slot          = 6'(best);
          o.id            = tbl_id[best];
        end else begin
          o.status = pts_pkg::STAT_NO_CURRENT;
        end
      end
      default: ;
    endcase
    if (c.act != pts_pkg::ACT_NONE) outcome_q.push_back(o);
  endtask

  task automatic push_cmd(input pts_pkg::action_e a, input logic [1:0] c,
                          input logic [7:0] p);
    command_t cmd;
    cmd.act  = a;
    cmd.cpu  = c;
    cmd.prio = p;
    cmd_q.push_back(cmd);
  endtask

  task automatic note_failure();
    fail_cnt++;
  endtask

  // Driver: hold an item until its transfer, then idle or present the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (start_i) begin
        run_table_op(cmd_q.pop_front());
        accepted_cnt++;
      end
      if (cmd_q.size() != 0 &&
          ((accepted_cnt >= 700 && accepted_cnt < 1000) || $urandom_range(99) >= 25)) begin
        start_i        <= 1'b1;
        action_i       <= cmd_q[0].act;
        cpu_i          <= cmd_q[0].cpu;
        priority_req_i <= cmd_q[0].prio;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected outcome.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("ERROR: result with nothing expected: status %0d slot %0d id %0d",
                   status_o, slot_o, task_id_o);
        note_failure();
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status || slot_o !== want.slot || task_id_o !== want.id) begin
          if (fail_cnt < MAX_REPORTS)
            $display("ERROR: expected status %0d slot %0d id %0d, got status %0d slot %0d id %0d",
                     want.status, want.slot, want.id, status_o, slot_o, task_id_o);
          note_failure();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    command_t    c;
    int unsigned r;
    for (int i = 0; i < pts_pkg::SLOTS; i++) tbl_state[i] = pts_pkg::ST_UNUSED;
    for (int i = 0; i < pts_pkg::CPUS; i++) begin
      cur_slot[i]  = '0;
      cur_valid[i] = 1'b0;
    end
    last_id = '0;

    push_cmd(pts_pkg::ACT_SCHED,  2'd0, 8'h00);   // empty table: nothing runnable
    push_cmd(pts_pkg::ACT_YIELD,  2'd1, 8'hFF);   // no current task yet
    push_cmd(pts_pkg::ACT_CREATE, 2'd3, 8'hFF);
    push_cmd(pts_pkg::ACT_CREATE, 2'd2, 8'h00);
    push_cmd(pts_pkg::ACT_CREATE, 2'd1, 8'h00);   // tie with the slot before
    push_cmd(pts_pkg::ACT_NONE,   2'd3, 8'hAA);   // dropped, no result
    push_cmd(pts_pkg::ACT_SCHED,  2'd0, 8'h55);
    push_cmd(pts_pkg::ACT_SCHED,  2'd1, 8'hAA);
    push_cmd(pts_pkg::ACT_SCHED,  2'd2, 8'h00);
    push_cmd(pts_pkg::ACT_SCHED,  2'd3, 8'h00);
    push_cmd(pts_pkg::ACT_YIELD,  2'd3, 8'h00);
    push_cmd(pts_pkg::ACT_YIELD,  2'd0, 8'h00);
    push_cmd(pts_pkg::ACT_YIELD,  2'd0, 8'h00);   // yield twice in a row
    push_cmd(pts_pkg::ACT_SCHED,  2'd3, 8'h00);
    push_cmd(pts_pkg::ACT_YIELD,  2'd0, 8'h00);   // slot now running on another cpu
    push_cmd(pts_pkg::ACT_CREATE, 2'd0, 8'h55);
    push_cmd(pts_pkg::ACT_CREATE, 2'd3, 8'hAA);
    push_cmd(pts_pkg::ACT_SCHED,  2'd2, 8'hFF);
    push_cmd(pts_pkg::ACT_YIELD,  2'd2, 8'hFF);

    // Creates are rare so the table fills about a third of the way in;
    // afterwards every create hits the full table.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r     = $urandom_range(99);
      c.cpu = 2'($urandom_range(3));
      if (r < 12)      c.act = pts_pkg::ACT_CREATE;
      else if (r < 52) c.act = pts_pkg::ACT_SCHED;
      else if (r < 95) c.act = pts_pkg::ACT_YIELD;
      else             c.act = pts_pkg::ACT_NONE;
      if ($urandom_range(1) == 0) c.prio = 8'($urandom_range(3));
      else                        c.prio = 8'($urandom_range(255));
      cmd_q.push_back(c);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start_i) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
